/* rtl/core/spd_pkg.sv */
`default_nettype none

package spd_pkg;

	localparam int MAX_NODES_DEF    = 64;
	localparam int INF_DISTANCE_DEF = 8191;
	localparam int WEIGHT_W         = 7;
	localparam int COUNT_W          = 7;

	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

	localparam logic [1:0] MODE_EDGE  = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_RUN   = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_RELAX,
		ST_RELAX_END,
		ST_OUT_RD,
		ST_OUT_LD
	} spd_state_t;

endpackage

`default_nettype wire

/* rtl/core/shortest_path_dijkstra.sv */
// shortest_path_dijkstra: single-source shortest paths over a stored weighted digraph.
// input channel (in_valid / in_stall): mode 0 writes one directed edge weight
// (0 removes it), mode 1 removes all edges, mode 2 runs from source_node.
// config channel (cfg_valid / cfg_ready, always ready): node_count, written while idle.
// output channel (out_valid / out_stall): one item per node in label order after a
// run, carrying node_index, path_distance, unreachable and last on the final node.
// clearing the edges writes all MAX_NODES*MAX_NODES entries, one weight memory entry per
// cycle; the same clearing pass runs after reset, and no input item is accepted until
// it is done.
// a run first initialises the distance of each of the n active nodes, then alternates
// scan and relax passes (one distance memory read per cycle) until no reachable node
// is left unvisited, then loads one result item per node.
// the result sits in an output register; a stalled receiver holds it and the block
// waits before loading the next one. after the last result is loaded the block
// takes the next input item while that result still waits.
`default_nettype none

module shortest_path_dijkstra import spd_pkg::*; #(
	parameter int MAX_NODES    = MAX_NODES_DEF,
	parameter int INF_DISTANCE = INF_DISTANCE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COUNT_W-1:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [5:0]          from_node,
	input  logic [5:0]          to_node,
	input  logic [WEIGHT_W-1:0] edge_weight,
	input  logic [5:0]          source_node,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [5:0]          node_index,
	output logic [12:0]         path_distance,
	output logic                unreachable,
	output logic                last
);

	localparam int NW    = $clog2(MAX_NODES);
	localparam int CW    = $clog2(MAX_NODES + 1);
	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = $clog2(INF_DISTANCE + 1);

	localparam logic [DW-1:0] INF_D  = DW'(INF_DISTANCE);
	localparam logic [DW-1:0] INF_M1 = DW'(INF_DISTANCE - 1);

	spd_state_t state_q, state_d;

	logic [WEIGHT_W-1:0] weight_mem [DEPTH];
	logic [DW:0]         dist_mem [MAX_NODES];

	logic                w_we;
	logic [AW-1:0]       w_wa, w_ra;
	logic [WEIGHT_W-1:0] w_wd;
	logic                d_we;
	logic [NW-1:0]       d_wa, d_ra;
	logic [DW:0]         d_wd;

	logic [WEIGHT_W-1:0] wt_rd_s1;
	logic [DW:0]         dist_rd_s1;
	logic [NW-1:0]       idx_s1;
	logic                scan_v_s1, relax_v_s1;

	logic [COUNT_W-1:0]  node_count_q;
	logic [AW-1:0]       clr_q;
	logic [NW-1:0]       idx_q;
	logic [CW-1:0]       n_q;
	logic [5:0]          src_q;
	logic                found_q;
	logic [DW-1:0]       min_q;
	logic [NW-1:0]       best_q;
	logic [NW-1:0]       u_q;
	logic [DW-1:0]       dist_u_q;
	logic [AW-1:0]       row_q;

	logic                out_valid_q;
	logic [5:0]          out_idx_q;
	logic [12:0]         out_dist_q;
	logic                out_unr_q, out_last_q;

	logic                in_acc, clr_last, idx_last, edge_ok;
	logic [CW-1:0]       n_active;
	logic [DW:0]         cand_sum;
	logic [DW-1:0]       cand;
	logic                upd, self_hit, take, rd_unr;

	assign cfg_ready     = 1'b1;
	assign in_acc        = in_valid && !in_stall;
	assign clr_last      = clr_q == AW'(DEPTH - 1);
	assign idx_last      = CW'(idx_q) == (n_q - CW'(1));
	assign edge_ok       = (int'(from_node) < MAX_NODES) && (int'(to_node) < MAX_NODES);

	always_comb begin
		if (node_count_q == '0) begin
			n_active = CW'(1);
		end else if (int'(node_count_q) > MAX_NODES) begin
			n_active = CW'(MAX_NODES);
		end else begin
			n_active = CW'(node_count_q);
		end
	end

	// relaxation of one edge out of the selected node
	assign cand_sum = {1'b0, dist_u_q} + (DW+1)'(wt_rd_s1);
	assign cand     = (cand_sum >= (DW+1)'(INF_DISTANCE)) ? INF_M1 : cand_sum[DW-1:0];
	assign upd      = (wt_rd_s1 != '0) && (cand < dist_rd_s1[DW-1:0]);
	assign self_hit = idx_s1 == u_q;

	// least unvisited distance, lowest label on ties
	assign take = scan_v_s1 && !dist_rd_s1[DW] && (!found_q || dist_rd_s1[DW-1:0] < min_q);

	assign rd_unr = dist_rd_s1[DW-1:0] >= INF_D;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		w_we     = 1'b0;
		w_wa     = clr_q;
		w_wd     = '0;
		w_ra     = row_q + AW'(idx_q);
		d_we     = 1'b0;
		d_wa     = idx_q;
		d_wd     = '0;
		d_ra     = idx_q;
		unique case (state_q)
			ST_CLEAR: begin
				w_we = 1'b1;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (mode)
						MODE_EDGE: begin
							w_we = edge_ok;
							w_wa = AW'(from_node) * AW'(MAX_NODES) + AW'(to_node);
							w_wd = edge_weight;
						end
						MODE_CLEAR: state_d = ST_CLEAR;
						MODE_RUN:   state_d = ST_INIT;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_INIT: begin
				d_we = 1'b1;
				d_wd = {1'b0, (int'(idx_q) == int'(src_q)) ? DW'(0) : INF_D};
				if (idx_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!found_q || min_q >= INF_D) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_RELAX;
				end
			end
			ST_RELAX: begin
				if (idx_last) begin
					state_d = ST_RELAX_END;
				end
			end
			ST_RELAX_END: state_d = ST_SCAN;
			ST_OUT_RD: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_OUT_LD;
				end
			end
			ST_OUT_LD: state_d = idx_last ? ST_IDLE : ST_OUT_RD;
			default:   state_d = ST_IDLE;
		endcase
		// write back of a relaxed entry; the selected node gets its done mark here
		if (relax_v_s1 && (self_hit || upd)) begin
			d_we = 1'b1;
			d_wa = idx_s1;
			d_wd = self_hit ? {1'b1, dist_rd_s1[DW-1:0]} : {dist_rd_s1[DW], cand};
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[w_wa] <= w_wd;
		end
		wt_rd_s1 <= weight_mem[w_ra];
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			dist_mem[d_wa] <= d_wd;
		end
		dist_rd_s1 <= dist_mem[d_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			clr_q        <= '0;
			idx_q        <= '0;
			scan_v_s1    <= 1'b0;
			relax_v_s1   <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			scan_v_s1  <= state_q == ST_SCAN;
			relax_v_s1 <= state_q == ST_RELAX;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + AW'(1);
			end
			if (state_q == ST_INIT || state_q == ST_SCAN || state_q == ST_RELAX
					|| state_q == ST_OUT_LD) begin
				idx_q <= idx_last ? '0 : idx_q + NW'(1);
			end
			if (state_q == ST_DECIDE) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_OUT_LD) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (in_acc) begin
			n_q   <= n_active;
			src_q <= source_node;
		end
		if (take) begin
			min_q  <= dist_rd_s1[DW-1:0];
			best_q <= idx_s1;
		end
		if (state_q == ST_DECIDE) begin
			u_q      <= best_q;
			dist_u_q <= min_q;
			row_q    <= AW'(best_q) * AW'(MAX_NODES);
		end
		if (state_q == ST_OUT_LD) begin
			out_idx_q  <= 6'(idx_q);
			out_dist_q <= rd_unr ? 13'd0 : dist_rd_s1[12:0];
			out_unr_q  <= rd_unr;
			out_last_q <= idx_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign node_index    = out_idx_q;
	assign path_distance = out_dist_q;
	assign unreachable   = out_unr_q;
	assign last          = out_last_q;

	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT_LD |-> !out_valid_q)
		else $error("result loaded over a waiting item");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT_LD) && idx_last |=> (state_q == ST_IDLE) && out_valid_q && out_last_q)
		else $error("final result not marked or run not ended");

	a_relax_window: assert property (@(posedge clk) disable iff (!arst_n)
		relax_v_s1 |-> (state_q == ST_RELAX || state_q == ST_RELAX_END))
		else $error("relax write outside relax phase");

endmodule

`default_nettype wire

/* tb/shortest_path_dijkstra_tb.sv */
`timescale 1ns / 1ps

module shortest_path_dijkstra_tb;
	import spd_pkg::*;

	localparam int NODES = MAX_NODES_DEF;
	localparam int INF = INF_DISTANCE_DEF;
	localparam int CLEAR_CYCLES = NODES * NODES;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [5:0]  node;
		logic [12:0] cost;
		logic        unr;
		logic        last;
	} path_result_t;

	class path_board;
		bit [6:0] weights [NODES][NODES];
		bit [6:0] count_reg;
		path_result_t due[$];
		int errors;
		int checked;
		int runs;
		int clears;
		int edges;

		function new();
			count_reg = NODE_COUNT_RST;
			errors = 0;
			checked = 0;
			runs = 0;
			clears = 0;
			edges = 0;
		endfunction

		function void set_count(bit [6:0] v);
			count_reg = v;
		endfunction

		function int pending();
			return due.size();
		endfunction

		task report_mismatch(int node, string what, int got, int want);
			$display("tb: mismatch at node %0d: %s got %0d expected %0d", node, what, got, want);
			errors++;
		endtask

		function void compute_paths(bit [5:0] src);
			int n;
			int best [NODES];
			bit seen [NODES];
			int u;
			bit found;
			int cand;
			path_result_t r;
			n = count_reg;
			if (n == 0) n = 1;
			if (n > NODES) n = NODES;
			for (int i = 0; i < n; i++) begin
				best[i] = INF;
				seen[i] = 0;
			end
			if (src < n) best[src] = 0;
			for (int k = 0; k < n; k++) begin
				found = 0;
				u = 0;
				for (int j = 0; j < n; j++) begin
					if (!seen[j] && (!found || best[j] < best[u])) begin
						u = j;
						found = 1;
					end
				end
				if (!found || best[u] >= INF) break;
				seen[u] = 1;
				for (int j = 0; j < n; j++) begin
					if (weights[u][j] != 0) begin
						cand = best[u] + weights[u][j];
						if (cand >= INF) cand = INF - 1;
						if (cand < best[j]) best[j] = cand;
					end
				end
			end
			for (int i = 0; i < n; i++) begin
				r.node = 6'(i);
				r.unr = best[i] >= INF;
				r.cost = r.unr ? 13'd0 : 13'(best[i]);
				r.last = (i == n - 1);
				due.push_back(r);
			end
		endfunction

		function void note_item(logic [1:0] m, logic [5:0] f, logic [5:0] t,
				logic [6:0] w, logic [5:0] s);
			case (m)
				MODE_EDGE: begin
					weights[f][t] = w;
					edges++;
				end
				MODE_CLEAR: begin
					foreach (weights[i, j]) weights[i][j] = 0;
					clears++;
				end
				MODE_RUN: begin
					compute_paths(s);
					runs++;
				end
				default: ;
			endcase
		endfunction

		task check_result(path_result_t got);
			path_result_t want;
			if (due.size() == 0) begin
				report_mismatch(got.node, "unexpected item, node_index", got.node, 0);
				return;
			end
			want = due.pop_front();
			checked++;
			if (got.node !== want.node)
				report_mismatch(want.node, "node_index", got.node, want.node);
			if (got.cost !== want.cost)
				report_mismatch(want.node, "path_distance", got.cost, want.cost);
			if (got.unr !== want.unr)
				report_mismatch(want.node, "unreachable", got.unr, want.unr);
			if (got.last !== want.last)
				report_mismatch(want.node, "last", got.last, want.last);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] mode;
	logic [5:0] from_node;
	logic [5:0] to_node;
	logic [WEIGHT_W-1:0] edge_weight;
	logic [5:0] source_node;
	logic out_valid;
	logic out_stall;
	logic [5:0] node_index;
	logic [12:0] path_distance;
	logic unreachable;
	logic last;

	path_board board = new();
	path_result_t seen_item;
	int send_pct;
	int recv_pct;
	bit hold_long;
	int items_sent;
	int settings;

	shortest_path_dijkstra u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.from_node(from_node),
		.to_node(to_node),
		.edge_weight(edge_weight),
		.source_node(source_node),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.node_index(node_index),
		.path_distance(path_distance),
		.unreachable(unreachable),
		.last(last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		out_stall = hold_long || ($urandom_range(99) < recv_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_item = {node_index, path_distance, unreachable, last};
			board.check_result(seen_item);
		end
	end

	task automatic send_item(logic [1:0] m, logic [5:0] f, logic [5:0] t,
			logic [6:0] w, logic [5:0] s);
		while ($urandom_range(99) < send_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		from_node = f;
		to_node = t;
		edge_weight = w;
		source_node = s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_item(m, f, t, w, s);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (CLEAR_CYCLES + 100) @(negedge clk);
	endtask

	task automatic write_count(logic [6:0] v);
		settle();
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_count(v);
		settings++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [5:0] pick_node(int nact);
		if ($urandom_range(9) == 0) return 6'($urandom_range(63));
		return 6'($urandom_range(nact - 1));
	endfunction

	task automatic random_item(int nact, output bit ignored);
		int roll;
		int wroll;
		logic [1:0] m;
		logic [6:0] w;
		roll = $urandom_range(99);
		wroll = $urandom_range(19);
		if (roll < 3) m = MODE_CLEAR;
		else if (roll < 6) m = MODE_SPARE;
		else if (roll < 26) m = MODE_RUN;
		else m = MODE_EDGE;
		if (wroll == 0) w = 7'd0;
		else if (wroll == 1) w = 7'($urandom_range(127, 100));
		else w = 7'($urandom_range(99, 1));
		send_item(m, pick_node(nact), pick_node(nact), w, pick_node(nact));
		ignored = (m == MODE_SPARE);
	endtask

	task automatic phase(logic [6:0] cnt, int sp, int rp, int items, bit squeeze);
		int nact;
		int done;
		bit ignored;
		write_count(cnt);
		send_pct = sp;
		recv_pct = rp;
		nact = (cnt == 0) ? 1 : (cnt > NODES) ? NODES : cnt;
		done = 0;
		if (squeeze) begin
			fork
				begin
					hold_long = 1'b1;
					repeat (400) @(negedge clk);
					hold_long = 1'b0;
				end
			join_none
			send_item(MODE_RUN, 6'd0, 6'd0, 7'd0, 6'd63);
			send_item(MODE_RUN, 6'd0, 6'd0, 7'd0, 6'd0);
			done = 2;
		end
		while (done < items) begin
			random_item(nact, ignored);
			if (!ignored) done++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_EDGE;
		from_node = '0;
		to_node = '0;
		edge_weight = '0;
		source_node = '0;
		out_stall = 1'b0;
		hold_long = 1'b0;
		send_pct = 0;
		recv_pct = 0;
		items_sent = 0;
		settings = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// empty graph, reset node count, self edge, weight above range, removal
		send_item(MODE_RUN, 6'd0, 6'd0, 7'd0, 6'd0);
		send_item(MODE_EDGE, 6'd0, 6'd63, 7'd99, 6'd0);
		send_item(MODE_EDGE, 6'd63, 6'd0, 7'd127, 6'd0);
		send_item(MODE_EDGE, 6'd0, 6'd0, 7'd5, 6'd0);
		send_item(MODE_EDGE, 6'd0, 6'd1, 7'd1, 6'd0);
		send_item(MODE_EDGE, 6'd1, 6'd63, 7'd1, 6'd0);
		send_item(MODE_EDGE, 6'd5, 6'd6, 7'd42, 6'd0);
		send_item(MODE_SPARE, 6'd63, 6'd63, 7'd127, 6'd63);
		send_item(MODE_RUN, 6'd0, 6'd0, 7'd0, 6'd0);
		send_item(MODE_EDGE, 6'd1, 6'd63, 7'd0, 6'd0);
		send_item(MODE_RUN, 6'd0, 6'd0, 7'd0, 6'd63);
		send_item(MODE_CLEAR, 6'd0, 6'd0, 7'd0, 6'd0);
		send_item(MODE_RUN, 6'd0, 6'd0, 7'd0, 6'd63);

		phase(7'd1, 0, 0, 8, 1'b0);
		phase(7'd0, 54, 0, 6, 1'b0);
		phase(7'd127, 0, 54, 12, 1'b0);
		phase(7'd7, 38, 38, 25, 1'b1);
		phase(7'd12, 0, 0, 12, 1'b0);
		phase(7'd5, 54, 0, 20, 1'b0);
		phase(7'd20, 0, 54, 20, 1'b0);
		phase(7'd3, 38, 38, 20, 1'b0);

		in_valid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (200) @(negedge clk);

		$display("tb: %0d items sent (%0d runs, %0d edge writes, %0d clears), %0d results checked",
			items_sent, board.runs, board.edges, board.clears, board.checked);
		$display("tb: %0d node count settings, mixed idle and stall, one long output hold",
			settings);
		if (board.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/spd_pkg.sv
rtl/core/shortest_path_dijkstra.sv
tb/shortest_path_dijkstra_tb.sv
